@@ rtl/su8u16_pkg.sv @@
package su8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 2;

  localparam logic [CpW-1:0] CpMin2   = 21'h00_0080;
  localparam logic [CpW-1:0] CpMin3   = 21'h00_0800;
  localparam logic [CpW-1:0] CpMin4   = 21'h01_0000;
  localparam logic [CpW-1:0] CpMax    = 21'h10_FFFF;
  localparam logic [CpW-1:0] SurLo    = 21'h00_D800;
  localparam logic [CpW-1:0] SurHi    = 21'h00_DFFF;
  localparam logic [CpW-1:0] BmpMax   = 21'h00_FFFF;
  localparam logic [UnitW-1:0] HiBase = 16'hD800;
  localparam logic [UnitW-1:0] LoBase = 16'hDC00;

  localparam logic [CountW-1:0] Len1 = 2'd1;
  localparam logic [CountW-1:0] Len2 = 2'd2;
  localparam logic [CountW-1:0] Len3 = 2'd3;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             status;
    logic             string_end;
    logic             last_of_run;
  } unit_t;

endpackage

@@ rtl/su8u16_if.sv @@
interface su8u16_byte_if;
  logic                         valid;
  logic                         ready;
  logic [su8u16_pkg::ByteW-1:0] byte_value;
  logic                         end_of_string;

  modport source (output valid, output byte_value, output end_of_string, input ready);
  modport sink (input valid, input byte_value, input end_of_string, output ready);
endinterface

interface su8u16_unit_if;
  logic                         valid;
  logic                         ready;
  logic [su8u16_pkg::UnitW-1:0] code_unit;
  logic                         status;
  logic                         string_end;
  logic                         last_of_run;

  modport source (output valid, output code_unit, output status, output string_end,
                  output last_of_run, input ready);
  modport sink (input valid, input code_unit, input status, input string_end,
                input last_of_run, output ready);
endinterface

@@ rtl/strict_utf8_to_utf16_transcoder.sv @@
// strict utf-8 to utf-16 transcoder
// in_i carries one utf-8 byte per word, with end_of_string set on the last
// byte of a string. out_o carries one utf-16 code unit per word, with status,
// string_end and last_of_run flags. a code point above the bmp gives two
// words (high then low surrogate). a malformed string gives no further units
// and a single rejection word (status 1, code unit 0) at its final byte; the
// receiver drops any units of that string it already took.
// a word is registered on out_o in the cycle after the byte that completes it.
// one byte per cycle while in_i.ready is high; the decode is one pass of logic
// from the sequence state to the output register. a surrogate pair occupies
// both output slots, and the byte after it is held off while the low
// surrogate waits in the second slot.
// when the receiver stalls, the output register holds its word and in_i.ready
// drops once both output slots are full or the held word cannot leave.
// reset clears the sequence state, the error flag and both output slots.
module strict_utf8_to_utf16_transcoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  su8u16_byte_if.sink           in_i,
  su8u16_unit_if.source         out_o
);

  logic [su8u16_pkg::CountW-1:0] pend_q, pend_d;
  logic [su8u16_pkg::CountW-1:0] len_q, len_d;
  logic [su8u16_pkg::CpW-1:0]    acc_q, acc_d;
  logic                          failed_q, failed_d;

  logic              cur_valid_q, cur_valid_d;
  logic              nxt_valid_q, nxt_valid_d;
  su8u16_pkg::unit_t cur_q, cur_d;
  su8u16_pkg::unit_t nxt_q, nxt_d;

  logic [1:0]                 n_res;
  su8u16_pkg::unit_t          r0, r1;
  logic [su8u16_pkg::ByteW-1:0] b;
  logic                       eos;
  logic                       in_acc;
  logic                       out_take;
  logic [su8u16_pkg::CpW-1:0] acc_shift;
  logic [su8u16_pkg::CpW-1:0] cp;
  logic [19:0]                v;
  logic                       do_emit;
  logic                       do_fail;
  logic                       bad;

  assign b        = in_i.byte_value;
  assign eos      = in_i.end_of_string;
  assign in_i.ready = !nxt_valid_q && (!cur_valid_q || out_o.ready);
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_take = cur_valid_q && out_o.ready;
  assign acc_shift = {acc_q[su8u16_pkg::CpW-7:0], b[5:0]};
  assign v        = cp[19:0] - 20'h1_0000;

  always_comb begin
    pend_d   = pend_q;
    len_d    = len_q;
    acc_d    = acc_q;
    failed_d = failed_q;
    do_emit  = 1'b0;
    do_fail  = 1'b0;
    bad      = 1'b0;
    cp       = acc_shift;
    if (failed_q) begin
      do_fail = eos;
    end else if (pend_q == '0) begin
      cp = {13'd0, b};
      if (!b[7]) begin
        do_emit = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        pend_d  = su8u16_pkg::Len1;
        acc_d   = {16'd0, b[4:0]};
        do_fail = eos;
      end else if (b[7:4] == 4'b1110) begin
        pend_d  = su8u16_pkg::Len2;
        acc_d   = {17'd0, b[3:0]};
        do_fail = eos;
      end else if (b[7:3] == 5'b11110) begin
        pend_d  = su8u16_pkg::Len3;
        acc_d   = {18'd0, b[2:0]};
        do_fail = eos;
      end else begin
        do_fail = 1'b1;
      end
      len_d = pend_d;
    end else if (b[7:6] != 2'b10) begin
      do_fail = 1'b1;
    end else if (pend_q != su8u16_pkg::Len1) begin
      pend_d  = pend_q - 2'd1;
      acc_d   = acc_shift;
      do_fail = eos;
    end else begin
      unique case (len_q)
        su8u16_pkg::Len1: bad = cp < su8u16_pkg::CpMin2;
        su8u16_pkg::Len2: bad = cp < su8u16_pkg::CpMin3 ||
                               (cp >= su8u16_pkg::SurLo && cp <= su8u16_pkg::SurHi);
        default:          bad = cp < su8u16_pkg::CpMin4 || cp > su8u16_pkg::CpMax;
      endcase
      do_fail = bad;
      do_emit = !bad;
    end

    n_res = 2'd0;
    r0    = '{code_unit: '0, status: 1'b1, string_end: 1'b1, last_of_run: 1'b1};
    r1    = '{code_unit: su8u16_pkg::LoBase | {6'd0, v[9:0]}, status: 1'b0,
              string_end: eos, last_of_run: 1'b1};
    if (do_fail) begin
      pend_d   = '0;
      len_d    = '0;
      acc_d    = '0;
      failed_d = !eos;
      n_res    = eos ? 2'd1 : 2'd0;
    end else if (do_emit) begin
      pend_d = '0;
      len_d  = '0;
      acc_d  = '0;
      if (cp <= su8u16_pkg::BmpMax) begin
        n_res = 2'd1;
        r0    = '{code_unit: cp[15:0], status: 1'b0, string_end: eos, last_of_run: 1'b1};
      end else begin
        n_res = 2'd2;
        r0    = '{code_unit: su8u16_pkg::HiBase | {6'd0, v[19:10]}, status: 1'b0,
                  string_end: 1'b0, last_of_run: 1'b0};
      end
    end
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    nxt_valid_d = nxt_valid_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    if (out_take) begin
      cur_valid_d = nxt_valid_q;
      cur_d       = nxt_q;
      nxt_valid_d = 1'b0;
    end
    if (in_acc && n_res != 2'd0) begin
      cur_valid_d = 1'b1;
      cur_d       = r0;
      nxt_valid_d = n_res == 2'd2;
      nxt_d       = r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      len_q       <= '0;
      acc_q       <= '0;
      failed_q    <= 1'b0;
      cur_valid_q <= 1'b0;
      nxt_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        pend_q   <= pend_d;
        len_q    <= len_d;
        acc_q    <= acc_d;
        failed_q <= failed_d;
      end
      cur_valid_q <= cur_valid_d;
      nxt_valid_q <= nxt_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    nxt_q <= nxt_d;
  end

  assign out_o.valid       = cur_valid_q;
  assign out_o.code_unit   = cur_q.code_unit;
  assign out_o.status      = cur_q.status;
  assign out_o.string_end  = cur_q.string_end;
  assign out_o.last_of_run = cur_q.last_of_run;

  a_nxt_needs_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nxt_valid_q |-> cur_valid_q)
    else $error("second slot full with first slot empty");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && eos |=> pend_q == '0 && len_q == '0 && !failed_q)
    else $error("state not cleared after end of string");

  a_fail_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> pend_q == '0 && len_q == '0)
    else $error("pending sequence in failed string");

  a_pend_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= len_q)
    else $error("more bytes pending than sequence length");

endmodule

@@ bench/strict_utf8_to_utf16_transcoder_tb.sv @@
module strict_utf8_to_utf16_transcoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LongStall   = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseBytes  = 474;
  localparam int unsigned NumDirected = 28;

  // bit 8 marks the final byte of a string
  localparam logic [8:0] DirectedBytes [NumDirected] = '{
    9'h07F, 9'h0C2, 9'h080, 9'h0EF, 9'h0BF, 9'h0BF, 9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,
    9'h100,
    9'h0C0, 9'h080, 9'h141,
    9'h0ED, 9'h0A0, 9'h180,
    9'h0F4, 9'h090, 9'h080, 9'h180,
    9'h180,
    9'h0FF, 9'h141,
    9'h0C2, 9'h141,
    9'h0E2, 9'h182
  };

  typedef logic [su8u16_pkg::ByteW-1:0] byte_t;
  typedef logic [su8u16_pkg::UnitW-1:0] word_t;
  typedef logic [su8u16_pkg::CpW-1:0]   cp_t;

  typedef struct packed {
    byte_t value;
    logic  last;
  } utf8_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  su8u16_byte_if in_bus ();
  su8u16_unit_if out_bus ();

  strict_utf8_to_utf16_transcoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  utf8_byte_t        pending_bytes [$];
  su8u16_pkg::unit_t expected_units [$];
  byte_t             utf8_scratch [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_served = 0;
  int unsigned stall_left = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned strings_taken = 0;
  int unsigned units_checked = 0;
  int unsigned pairs_checked = 0;
  int unsigned rejects_checked = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  logic        byte_taken = 1'b0;
  utf8_byte_t  drive_byte;

  // decoder state mirrored from the block
  logic [su8u16_pkg::CountW-1:0] conts_left = '0;
  logic [su8u16_pkg::CountW-1:0] seq_conts = '0;
  cp_t                           cp_acc = '0;
  logic                          str_bad = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("%0t: mismatch on %s, got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic expect_unit(input word_t unit, input logic bad,
                             input logic str_end, input logic last);
    su8u16_pkg::unit_t u;
    u.code_unit   = unit;
    u.status      = bad;
    u.string_end  = str_end;
    u.last_of_run = last;
    expected_units.insert(expected_units.size(), u);
  endtask

  task automatic mark_invalid(input logic eos);
    conts_left = '0;
    seq_conts  = '0;
    cp_acc     = '0;
    str_bad    = !eos;
    if (eos) expect_unit('0, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic expect_code_point(input cp_t cp, input logic eos);
    cp_t v;
    v = cp - su8u16_pkg::CpMin4;
    if (cp <= su8u16_pkg::BmpMax) begin
      expect_unit(cp[su8u16_pkg::UnitW-1:0], 1'b0, eos, 1'b1);
    end else begin
      expect_unit(su8u16_pkg::HiBase + word_t'(v[19:10]), 1'b0, 1'b0, 1'b0);
      expect_unit(su8u16_pkg::LoBase + word_t'(v[9:0]), 1'b0, eos, 1'b1);
    end
    conts_left = '0;
    seq_conts  = '0;
    cp_acc     = '0;
    str_bad    = 1'b0;
  endtask

  task automatic predict_byte(input byte_t b, input logic eos);
    cp_t  cp;
    logic bad;
    if (str_bad) begin
      if (eos) mark_invalid(1'b1);
      return;
    end
    if (conts_left == '0) begin
      if (b[7] == 1'b0) begin
        expect_code_point(cp_t'(b), eos);
        return;
      end
      if (b[7:5] == 3'b110) begin
        conts_left = su8u16_pkg::Len1;
        cp_acc     = cp_t'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        conts_left = su8u16_pkg::Len2;
        cp_acc     = cp_t'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        conts_left = su8u16_pkg::Len3;
        cp_acc     = cp_t'(b[2:0]);
      end else begin
        mark_invalid(eos);
        return;
      end
      seq_conts = conts_left;
      if (eos) mark_invalid(1'b1);
      return;
    end
    if (b[7:6] != 2'b10) begin
      mark_invalid(eos);
      return;
    end
    cp_acc     = {cp_acc[su8u16_pkg::CpW-7:0], b[5:0]};
    conts_left = conts_left - 1'b1;
    if (conts_left != '0) begin
      if (eos) mark_invalid(1'b1);
      return;
    end
    cp = cp_acc;
    case (seq_conts)
      su8u16_pkg::Len1: bad = cp < su8u16_pkg::CpMin2;
      su8u16_pkg::Len2: bad = cp < su8u16_pkg::CpMin3 ||
                              (cp >= su8u16_pkg::SurLo && cp <= su8u16_pkg::SurHi);
      default:          bad = cp < su8u16_pkg::CpMin4 || cp > su8u16_pkg::CpMax;
    endcase
    if (bad) mark_invalid(eos);
    else expect_code_point(cp, eos);
  endtask

  // output check first, then prediction for the byte taken at this edge
  always @(posedge clk_i) begin
    su8u16_pkg::unit_t want;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_units.size() == 0) begin
          report_mismatch("word with nothing expected", 32'(out_bus.code_unit), 32'h0);
        end else begin
          want = expected_units.pop_front();
          if (out_bus.code_unit !== want.code_unit)
            report_mismatch("code_unit", 32'(out_bus.code_unit), 32'(want.code_unit));
          if (out_bus.status !== want.status)
            report_mismatch("status", 32'(out_bus.status), 32'(want.status));
          if (out_bus.string_end !== want.string_end)
            report_mismatch("string_end", 32'(out_bus.string_end), 32'(want.string_end));
          if (out_bus.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 32'(out_bus.last_of_run), 32'(want.last_of_run));
          units_checked++;
          if (!want.last_of_run) pairs_checked++;
          if (want.status) rejects_checked++;
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        predict_byte(in_bus.byte_value, in_bus.end_of_string);
        bytes_taken++;
        if (in_bus.end_of_string) strings_taken++;
      end
      byte_taken <= in_bus.valid && in_bus.ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("strict_utf8_to_utf16_transcoder verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid         <= 1'b0;
      in_bus.byte_value    <= '0;
      in_bus.end_of_string <= 1'b0;
    end else if (!in_bus.valid || byte_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_byte = pending_bytes.pop_front();
        in_bus.valid         <= 1'b1;
        in_bus.byte_value    <= drive_byte.value;
        in_bus.end_of_string <= drive_byte.last;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_requests != stall_served) begin
      out_bus.ready <= 1'b0;
      stall_left    <= LongStall;
      stall_served  <= stall_served + 1;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_byte(input byte_t value, input logic last);
    utf8_byte_t item;
    item.value = value;
    item.last  = last;
    pending_bytes.insert(pending_bytes.size(), item);
    bytes_queued++;
  endtask

  task automatic add_scratch(input byte_t value);
    utf8_scratch.insert(utf8_scratch.size(), value);
  endtask

  // len may exceed the natural length to build overlong forms
  task automatic append_utf8(input int unsigned cp, input int unsigned len);
    case (len)
      1: add_scratch(byte_t'(cp & 'h7F));
      2: begin
        add_scratch(byte_t'('hC0 | ((cp >> 6) & 'h1F)));
        add_scratch(byte_t'('h80 | (cp & 'h3F)));
      end
      3: begin
        add_scratch(byte_t'('hE0 | ((cp >> 12) & 'h0F)));
        add_scratch(byte_t'('h80 | ((cp >> 6) & 'h3F)));
        add_scratch(byte_t'('h80 | (cp & 'h3F)));
      end
      default: begin
        add_scratch(byte_t'('hF0 | ((cp >> 18) & 'h07)));
        add_scratch(byte_t'('h80 | ((cp >> 12) & 'h3F)));
        add_scratch(byte_t'('h80 | ((cp >> 6) & 'h3F)));
        add_scratch(byte_t'('h80 | (cp & 'h3F)));
      end
    endcase
  endtask

  function automatic int unsigned random_code_point(input int unsigned len);
    int unsigned lo;
    int unsigned hi;
    int unsigned cp;
    int unsigned pick;
    case (len)
      1:       begin lo = 0;       hi = 'h7F;     end
      2:       begin lo = 'h80;    hi = 'h7FF;    end
      3:       begin lo = 'h800;   hi = 'hFFFF;   end
      default: begin lo = 'h10000; hi = 'h10FFFF; end
    endcase
    pick = $urandom_range(9);
    if (pick == 0) cp = lo;
    else if (pick == 1) cp = hi;
    else cp = $urandom_range(hi, lo);
    if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 'h2000;
    return cp;
  endfunction

  task automatic queue_random_string();
    int unsigned kind;
    int unsigned len;
    int unsigned pos;
    utf8_scratch = {};
    kind = $urandom_range(99);
    if (kind < 10) begin
      len = $urandom_range(6, 1);
      repeat (len) add_scratch(byte_t'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(6, 1)) begin
        len = $urandom_range(4, 1);
        append_utf8(random_code_point(len), len);
      end
      if (kind >= 75) begin
        case ($urandom_range(5))
          0: begin
            pos = $urandom_range(utf8_scratch.size() - 1);
            utf8_scratch[pos] = byte_t'($urandom_range(255));
          end
          1: begin
            if (utf8_scratch.size() > 1) void'(utf8_scratch.pop_back());
            else utf8_scratch[0] = byte_t'($urandom_range(255, 'hC2));
          end
          2: begin
            len = $urandom_range(4, 2);
            case (len)
              2:       append_utf8($urandom_range('h7F), 2);
              3:       append_utf8($urandom_range('h7FF), 3);
              default: append_utf8($urandom_range('hFFFF), 4);
            endcase
          end
          3: append_utf8($urandom_range('hDFFF, 'hD800), 3);
          4: append_utf8($urandom_range('h1FFFFF, 'h110000), 4);
          default: begin
            pos = $urandom_range(utf8_scratch.size());
            utf8_scratch.insert(pos, byte_t'('h80 | $urandom_range('h3F)));
          end
        endcase
        if ($urandom_range(1) != 0) begin
          len = $urandom_range(4, 1);
          append_utf8(random_code_point(len), len);
        end
      end
    end
    foreach (utf8_scratch[i]) push_byte(utf8_scratch[i], i == utf8_scratch.size() - 1);
  endtask

  task automatic queue_random_bytes(input int unsigned count);
    int unsigned target;
    target = bytes_queued + count;
    while (bytes_queued < target) queue_random_string();
  endtask

  task automatic wait_drained();
    while (bytes_taken != bytes_queued || expected_units.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 57;
    foreach (DirectedBytes[i]) push_byte(DirectedBytes[i][7:0], DirectedBytes[i][8]);
    queue_random_bytes(PhaseBytes);
    wait_drained();

    send_idle_pct = 57;
    recv_idle_pct = 25;
    queue_random_bytes(PhaseBytes);
    wait_drained();

    // no idling, and the receiver blocks long enough to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_requests++;
    queue_random_bytes(PhaseBytes);
    wait_drained();

    $display("sent %0d utf-8 bytes in %0d strings, %0d strings rejected",
             bytes_taken, strings_taken, rejects_checked);
    $display("checked %0d utf-16 words, %0d surrogate pairs, %0d mismatches",
             units_checked, pairs_checked, error_count);
    if (error_count == 0) begin
      $display("strict_utf8_to_utf16_transcoder verification clean");
    end else begin
      $display("strict_utf8_to_utf16_transcoder verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/su8u16_pkg.sv
rtl/su8u16_if.sv
rtl/strict_utf8_to_utf16_transcoder.sv
bench/strict_utf8_to_utf16_transcoder_tb.sv
